@@ rtl/prefix_code_stream_decoder_assert.svh @@
// assertion macros used by the checker file
`ifndef PREFIX_CODE_STREAM_DECODER_ASSERT_SVH
`define PREFIX_CODE_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define PCSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define PCSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pcsd_pkg.sv @@
// shared types and constants of the prefix code stream decoder
package pcsd_pkg;

	localparam int SYMBOL_COUNT    = 256;
	localparam int BUFFER_BITS     = 32;
	localparam int CODE_BYTES_KEPT = 4;
	localparam int MAX_RESULTS     = 8;

	// header parse phases
	localparam logic [2:0] PH_COUNT  = 3'd0;
	localparam logic [2:0] PH_SYMBOL = 3'd1;
	localparam logic [2:0] PH_LENGTH = 3'd2;
	localparam logic [2:0] PH_CODE   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;

	// write request into the code table
	typedef struct packed {
		logic        clr_all;
		logic        we;
		logic [7:0]  sym;
		logic [7:0]  len;
		logic [31:0] code;
	} tbl_wr_t;

	// registered read result of the code table
	typedef struct packed {
		logic        valid;
		logic [7:0]  len;
		logic [31:0] code;
	} tbl_rd_t;

endpackage

@@ rtl/pcsd_table.sv @@
// code table: per-symbol length and code memory plus valid bits
module pcsd_table (
	input  logic              clk,
	input  logic              arst_n,
	input  pcsd_pkg::tbl_wr_t wr,
	input  logic [7:0]        rd_idx,
	input  logic [7:0]        cur_sym,
	output pcsd_pkg::tbl_rd_t rd,
	output logic              cur_valid
);
	import pcsd_pkg::*;

	logic [7:0]  len_mem [SYMBOL_COUNT];
	logic [31:0] code_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] valid_q;
	logic        rd_valid_q;
	logic [7:0]  rd_len_q;
	logic [31:0] rd_code_q;

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr.we) begin
			len_mem[wr.sym]  <= wr.len;
			code_mem[wr.sym] <= wr.code;
		end
		rd_len_q  <= len_mem[rd_idx];
		rd_code_q <= code_mem[rd_idx];
	end

	// valid bits, cleared at once by a count byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.clr_all) begin
				valid_q <= '0;
			end else if (wr.we) begin
				valid_q[wr.sym] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd        = '{valid: rd_valid_q, len: rd_len_q, code: rd_code_q};
	assign cur_valid = valid_q[cur_sym];

endmodule

@@ rtl/prefix_code_stream_decoder.sv @@
// top level of the prefix code stream decoder
// Decodes a byte stream that carries its own prefix code table in a header.
// Header bytes (count, then symbol, length and code bytes per entry) are
// taken one per cycle. A data byte is accepted, then for every decoded
// symbol the 256-entry code table is swept through its single read port
// and the symbol is emitted; one closing sweep that finds no match (left
// out after the eighth symbol) and a finish step end the byte. A byte
// that would overflow the 32-bit bit buffer skips the sweeps, goes to the
// finish step and yields one error transfer. in_stall stays high while a
// byte is at work.
module prefix_code_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] symbol,
	output logic       overflow_error,
	output logic       run_end
);
	import pcsd_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]  state_q;
	logic [2:0]  phase_q;
	logic [8:0]  entries_left_q;
	logic [7:0]  cur_sym_q;
	logic [7:0]  code_left_q;
	logic [7:0]  cur_len_q;
	logic [31:0] code_acc_q;
	logic [31:0] buf_q;
	logic [5:0]  fill_q;
	logic        last_q;
	logic [8:0]  scan_cnt_q;
	logic        s1_v_s1;
	logic [7:0]  s1_idx_s1;
	logic        best_hit_q;
	logic [5:0]  best_len_q;
	logic [7:0]  best_sym_q;
	logic [3:0]  n_q;
	logic        pend_v_q;
	logic [7:0]  pend_sym_q;
	logic        pend_err_q;
	logic        out_valid_q;
	logic [7:0]  out_sym_q;
	logic        out_err_q;
	logic        out_end_q;

	tbl_wr_t     tbl_wr;
	tbl_rd_t     tbl_rd;
	logic        cur_valid;

	logic        accept;
	logic        writable;
	logic [7:0]  k_idx;
	logic [31:0] acc_next;
	logic [7:0]  code_left_dec;
	logic        finish;
	logic [8:0]  entries_dec;
	logic        hit;
	logic [31:0] lead;
	logic        scan_end;
	logic        can_push;
	logic        push;
	logic        push_end;
	logic [5:0]  rest;

	pcsd_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (tbl_wr),
		.rd_idx    (scan_cnt_q[7:0]),
		.cur_sym   (cur_sym_q),
		.rd        (tbl_rd),
		.cur_valid (cur_valid)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign can_push = !out_valid_q || !out_stall;

	// header entry handling
	always_comb begin
		writable      = ({1'b0, cur_sym_q} < 9'(SYMBOL_COUNT)) && !cur_valid;
		k_idx         = cur_len_q - code_left_q;
		acc_next      = code_acc_q;
		if (k_idx < 8'(CODE_BYTES_KEPT) && k_idx < 8'd4) begin
			acc_next = code_acc_q | (32'(data_byte) << {k_idx[1:0], 3'b000});
		end
		code_left_dec = code_left_q - 8'd1;
		entries_dec   = entries_left_q - 9'd1;
		finish        = 1'b0;
		tbl_wr        = '0;
		tbl_wr.sym    = cur_sym_q;
		if (accept) begin
			unique case (phase_q)
				PH_COUNT: tbl_wr.clr_all = 1'b1;
				PH_LENGTH: begin
					finish      = (data_byte == 8'd0);
					tbl_wr.len  = data_byte;
					tbl_wr.code = '0;
				end
				PH_CODE: begin
					finish      = (code_left_dec == 8'd0);
					tbl_wr.len  = cur_len_q;
					tbl_wr.code = acc_next;
				end
				default: ;
			endcase
		end
		tbl_wr.we = finish && writable;
	end

	// match check of the entry read last cycle
	always_comb begin
		lead     = buf_q >> (fill_q - tbl_rd.len[5:0]);
		hit      = s1_v_s1 && tbl_rd.valid && (tbl_rd.len != 8'd0) &&
		           (tbl_rd.len <= {2'b00, fill_q}) && (tbl_rd.code == lead) &&
		           (tbl_rd.len[5:0] < best_len_q);
		scan_end = s1_v_s1 && (s1_idx_s1 == 8'hFF);
		rest     = fill_q - best_len_q;
	end

	// result transfer into the output register
	always_comb begin
		push     = 1'b0;
		push_end = 1'b0;
		if (state_q == ST_EMIT && pend_v_q && can_push) begin
			push = 1'b1;
		end else if (state_q == ST_FLUSH && pend_v_q && can_push) begin
			push     = 1'b1;
			push_end = 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_sym_q <= pend_sym_q;
			out_err_q <= pend_err_q;
			out_end_q <= push_end;
		end
	end

	// sequencer and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_COUNT;
			entries_left_q <= '0;
			cur_sym_q      <= '0;
			code_left_q    <= '0;
			cur_len_q      <= '0;
			code_acc_q     <= '0;
			buf_q          <= '0;
			fill_q         <= '0;
			last_q         <= 1'b0;
			scan_cnt_q     <= '0;
			s1_v_s1        <= 1'b0;
			s1_idx_s1      <= '0;
			best_hit_q     <= 1'b0;
			best_len_q     <= '1;
			best_sym_q     <= '0;
			n_q            <= '0;
			pend_v_q       <= 1'b0;
			pend_sym_q     <= '0;
			pend_err_q     <= 1'b0;
		end else begin
			s1_v_s1   <= (state_q == ST_SCAN) && !scan_cnt_q[8];
			s1_idx_s1 <= scan_cnt_q[7:0];
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= end_of_stream;
						unique case (phase_q)
							PH_COUNT: begin
								entries_left_q <= 9'(data_byte) + 9'd1;
								phase_q        <= PH_SYMBOL;
							end
							PH_SYMBOL: begin
								cur_sym_q <= data_byte;
								phase_q   <= PH_LENGTH;
							end
							PH_LENGTH: begin
								cur_len_q   <= data_byte;
								code_acc_q  <= '0;
								code_left_q <= data_byte;
								if (data_byte != 8'd0) begin
									phase_q <= PH_CODE;
								end
							end
							PH_CODE: begin
								code_acc_q  <= acc_next;
								code_left_q <= code_left_dec;
							end
							PH_DATA: begin
								if (fill_q > 6'(BUFFER_BITS - 8)) begin
									buf_q      <= '0;
									fill_q     <= '0;
									pend_v_q   <= 1'b1;
									pend_sym_q <= '0;
									pend_err_q <= 1'b1;
									state_q    <= ST_FLUSH;
								end else begin
									buf_q      <= {buf_q[23:0], data_byte};
									fill_q     <= fill_q + 6'd8;
									n_q        <= '0;
									scan_cnt_q <= '0;
									best_hit_q <= 1'b0;
									best_len_q <= '1;
									state_q    <= ST_SCAN;
								end
							end
							default: phase_q <= PH_COUNT;
						endcase
						if (finish) begin
							entries_left_q <= entries_dec;
							phase_q        <= (entries_dec == 9'd0) ? PH_DATA : PH_SYMBOL;
						end
						// end of stream during the header
						if (end_of_stream && phase_q != PH_DATA) begin
							phase_q        <= PH_COUNT;
							entries_left_q <= '0;
							code_left_q    <= '0;
							buf_q          <= '0;
							fill_q         <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (!scan_cnt_q[8]) begin
						scan_cnt_q <= scan_cnt_q + 9'd1;
					end
					if (hit) begin
						best_hit_q <= 1'b1;
						best_len_q <= tbl_rd.len[5:0];
						best_sym_q <= s1_idx_s1;
					end
					if (scan_end) begin
						state_q <= (hit || best_hit_q) ? ST_EMIT : ST_FLUSH;
					end
				end
				ST_EMIT: begin
					if (!pend_v_q || can_push) begin
						pend_v_q   <= 1'b1;
						pend_sym_q <= best_sym_q;
						pend_err_q <= 1'b0;
						fill_q     <= rest;
						buf_q      <= buf_q & ~(32'hFFFF_FFFF << rest);
						n_q        <= n_q + 4'd1;
						scan_cnt_q <= '0;
						best_hit_q <= 1'b0;
						best_len_q <= '1;
						state_q    <= (n_q + 4'd1 == 4'(MAX_RESULTS)) ? ST_FLUSH : ST_SCAN;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || can_push) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
						if (last_q) begin
							phase_q        <= PH_COUNT;
							entries_left_q <= '0;
							code_left_q    <= '0;
							buf_q          <= '0;
							fill_q         <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign symbol         = out_sym_q;
	assign overflow_error = out_err_q;
	assign run_end        = out_end_q;

endmodule

@@ rtl/pcsd_checker.sv @@
// port-level checks of the prefix code stream decoder and their binding
`include "prefix_code_stream_decoder_assert.svh"

module pcsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] data_byte,
	input logic       end_of_stream,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] symbol,
	input logic       overflow_error,
	input logic       run_end
);
	// a stalled result transfer holds
	`PCSD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(symbol) && $stable(overflow_error) && $stable(run_end), "stalled result changed")
	// an error result is alone and carries symbol zero
	`PCSD_ASSERT_IMP(a_err_form, clk, arst_n, out_valid && overflow_error, run_end && symbol == 8'd0, "malformed error result")
	// while a byte still owes its final result no new byte is taken
	`PCSD_ASSERT_IMP(a_busy, clk, arst_n, out_valid && !run_end, in_stall, "input taken before run end")

endmodule

bind prefix_code_stream_decoder pcsd_checker u_pcsd_checker (.*);
